/* src/shs_pkg.sv */
// Shared types and constants for the SHA-1 stream hasher.
// Used by the top level and its port checker; depends on nothing else.
package shs_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ADD,
        ST_EMIT
    } shs_state_t;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] LAST_POS    = 6'd63;
    localparam logic [3:0] LEN_HI_WORD = 4'd14;
    localparam logic [3:0] LEN_LO_WORD = 4'd15;

    localparam logic [6:0] LOAD_CNT       = 7'd0;
    localparam logic [6:0] OPEN_WRITE_CNT = 7'd16;
    localparam logic [6:0] LAST_ROUND_CNT = 7'd80;
    localparam logic [6:0] SCHED_ROUND    = 7'd16;
    localparam logic [6:0] ROUND_F2       = 7'd20;
    localparam logic [6:0] ROUND_F3       = 7'd40;
    localparam logic [6:0] ROUND_F4       = 7'd60;

    localparam logic [2:0] LAST_IDX = 3'd4;

    localparam logic [4:0][31:0] INIT_WORDS = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [3:0][31:0] ROUND_K = {
        32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
    };

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } shs_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } shs_out_t;

endpackage

/* src/sha1_stream_hasher.sv */
// SHA-1 stream hasher top level: block buffer memory, 80-round compression and digest output.
// Depends on shs_pkg.
//
//   channel  | ports                      | payload
//   request  | s_valid, s_ready, s_data   | shs_in_t (op, data_byte)
//   digest   | m_valid, m_ready, m_data   | shs_out_t (digest_word, word_index, last_word)
//
// The 64th byte of a block starts a compression (one word read, 80 rounds, one chaining add);
// absorbs are taken again during its later rounds, once the schedule holds all 16 buffer words,
// except the next block's last byte.
// A finish request runs one or two compressions (two when 56 or more bytes are pending), then
// sends five digest words through an output register. Reset is synchronous on aresetn low.
// A low m_ready holds the current digest word and stalls the remaining ones.
module sha1_stream_hasher
    import shs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  shs_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output shs_out_t m_data
);

    logic [3:0][7:0] mem [16];
    logic [31:0]     rdata_reg;
    logic [3:0]      widx_reg;
    logic [3:0]      raddr;

    shs_state_t      state_reg, state_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic [60:0]     count_reg, count_next;
    logic [4:0][31:0] h_reg, h_next;
    logic [31:0]     a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [31:0]     d_reg, d_next, e_reg, e_next;
    logic [15:0][31:0] w_reg, w_next;
    logic            pad_reg, pad_next;
    logic            msk_reg, msk_next;
    logic            lenin_reg, lenin_next;
    logic            second_reg, second_next;
    logic [5:0]      padpos_reg, padpos_next;
    logic [63:0]     len_reg, len_next;
    logic [2:0]      oidx_reg, oidx_next;
    logic            m_valid_reg, m_valid_next;
    shs_out_t        m_data_reg, m_data_next;

    logic [5:0]      pos;
    logic            s_acc, absorb, finish, load;
    logic [6:0]      rnd;
    logic [31:0]     word_in, w_new, f_val, k_val, sched, t_val;
    logic [5:0]      bpos;

    assign pos     = count_reg[5:0];
    assign s_acc   = s_valid && s_ready;
    assign absorb  = s_acc && (s_data.op == OP_ABSORB);
    assign finish  = s_acc && (s_data.op == OP_FINISH);
    assign load    = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign raddr   = cnt_reg[3:0];
    assign rnd     = cnt_reg - 7'd1;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_RUN:  s_ready = (cnt_reg >= OPEN_WRITE_CNT) && !pad_reg && (pos != LAST_POS)
                               && (s_data.op == OP_ABSORB);
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (absorb) begin
            mem[pos[5:2]][~pos[1:0]] <= s_data.data_byte;
        end
        rdata_reg <= mem[raddr];
        widx_reg  <= raddr;
    end

    always_comb begin
        word_in = rdata_reg;
        bpos    = '0;
        if (pad_reg) begin
            for (int l = 0; l < 4; l++) begin
                bpos = {widx_reg, ~2'(l)};
                if (!msk_reg || (bpos > padpos_reg)) begin
                    word_in[8*l +: 8] = 8'h00;
                end else if (bpos == padpos_reg) begin
                    word_in[8*l +: 8] = PAD_BYTE;
                end
            end
            if (lenin_reg && (widx_reg == LEN_HI_WORD)) begin
                word_in = len_reg[63:32];
            end else if (lenin_reg && (widx_reg == LEN_LO_WORD)) begin
                word_in = len_reg[31:0];
            end
        end
    end

    always_comb begin
        sched = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = (rnd < SCHED_ROUND) ? word_in : {sched[30:0], sched[31]};
        if (rnd < ROUND_F2) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = ROUND_K[0];
        end else if (rnd < ROUND_F3) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = ROUND_K[1];
        end else if (rnd < ROUND_F4) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = ROUND_K[2];
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = ROUND_K[3];
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w_new + k_val;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if ((absorb && (pos == LAST_POS)) || finish) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg == LAST_ROUND_CNT) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (second_reg) begin
                    state_next = ST_RUN;
                end else if (pad_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (load && (oidx_reg == LAST_IDX)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cnt_next     = (state_reg == ST_RUN) ? cnt_reg + 7'd1 : LOAD_CNT;
        count_next   = absorb ? count_reg + 61'd1 : count_reg;
        h_next       = h_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        e_next       = e_reg;
        w_next       = w_reg;
        pad_next     = pad_reg;
        msk_next     = msk_reg;
        lenin_next   = lenin_reg;
        second_next  = second_reg;
        padpos_next  = padpos_reg;
        len_next     = len_reg;
        oidx_next    = oidx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (finish) begin
                    pad_next    = 1'b1;
                    msk_next    = 1'b1;
                    padpos_next = pos;
                    len_next    = {count_reg, 3'b000};
                    lenin_next  = (pos < LEN_POS);
                    second_next = (pos >= LEN_POS);
                end
            end
            ST_RUN: begin
                if (cnt_reg == LOAD_CNT) begin
                    a_next = h_reg[0];
                    b_next = h_reg[1];
                    c_next = h_reg[2];
                    d_next = h_reg[3];
                    e_next = h_reg[4];
                end else begin
                    a_next = t_val;
                    b_next = a_reg;
                    c_next = {b_reg[1:0], b_reg[31:2]};
                    d_next = c_reg;
                    e_next = d_reg;
                    w_next = {w_new, w_reg[15:1]};
                end
            end
            ST_ADD: begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                if (second_reg) begin
                    second_next = 1'b0;
                    msk_next    = 1'b0;
                    lenin_next  = 1'b1;
                end
            end
            ST_EMIT: begin
                if (load) begin
                    m_valid_next            = 1'b1;
                    m_data_next.digest_word = h_reg[oidx_reg];
                    m_data_next.word_index  = oidx_reg;
                    m_data_next.last_word   = (oidx_reg == LAST_IDX);
                    oidx_next               = oidx_reg + 3'd1;
                    if (oidx_reg == LAST_IDX) begin
                        oidx_next  = '0;
                        h_next     = INIT_WORDS;
                        count_next = '0;
                        pad_next   = 1'b0;
                    end
                end
            end
            default: begin
                pad_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= LOAD_CNT;
            count_reg   <= '0;
            h_reg       <= INIT_WORDS;
            pad_reg     <= 1'b0;
            second_reg  <= 1'b0;
            oidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            count_reg   <= count_next;
            h_reg       <= h_next;
            pad_reg     <= pad_next;
            second_reg  <= second_next;
            oidx_reg    <= oidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        w_reg      <= w_next;
        msk_reg    <= msk_next;
        lenin_reg  <= lenin_next;
        padpos_reg <= padpos_next;
        len_reg    <= len_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* src/shs_checker.sv */
// Port-level checker for the SHA-1 stream hasher, bound to the top level.
// Depends on shs_pkg and the sha1_stream_hasher port list.
module shs_checker
    import shs_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input shs_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input shs_out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Digest word changed or dropped while stalled.");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.word_index <= LAST_IDX)
        else $error("Digest word index out of range.");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_word == (m_data.word_index == LAST_IDX)))
        else $error("Last-word flag disagrees with word index.");

    a_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_word |=>
            m_valid && (m_data.word_index == $past(m_data.word_index) + 3'd1))
        else $error("Digest words are not sent back to back in order.");

    a_no_input_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_word |-> !s_ready)
        else $error("Request taken while a digest is being sent.");

endmodule

bind sha1_stream_hasher shs_checker u_shs_checker (.*);

/* bench/tb.sv */
// Self-checking bench for sha1_stream_hasher: directed and random byte messages,
// digest words checked against an in-bench SHA-1 computation with random stalls on both sides.
// Depends on shs_pkg and the sha1_stream_hasher RTL.
`timescale 1ns / 100ps

module tb
    import shs_pkg::*;
();

    typedef struct {
        shs_in_t req;
        bit      hold;
    } pending_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    shs_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    shs_out_t m_data;

    pending_t pending_q[$];
    shs_out_t digest_q[$];
    int       err_count = 0;

    logic [4:0][31:0] hash_h = INIT_WORDS;
    logic [7:0]       msg_block [0:63];
    logic [60:0]      msg_len = '0;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned sink_mode = 0;
    int unsigned sink_cycles = 0;

    sha1_stream_hasher dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic sha1_compress();
        logic [31:0] w [0:79];
        logic [31:0] a, b, c, d, e, f, t;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (i = 16; i < 80; i++) begin
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (i = 0; i < 80; i++) begin
            if (i < ROUND_F2) begin
                f = (b & c) | (~b & d);
            end else if (i < ROUND_F3 || i >= ROUND_F4) begin
                f = b ^ c ^ d;
            end else begin
                f = (b & c) | (b & d) | (c & d);
            end
            t = rotl(a, 5) + f + e + w[i] + ROUND_K[i / 20];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_h[0] = hash_h[0] + a;
        hash_h[1] = hash_h[1] + b;
        hash_h[2] = hash_h[2] + c;
        hash_h[3] = hash_h[3] + d;
        hash_h[4] = hash_h[4] + e;
    endtask

    // Updates the message state for one accepted request; a finish queues its five words.
    task automatic hash_request(shs_in_t req);
        int unsigned pos;
        logic [63:0] bit_len;
        shs_out_t word;
        int i;
        pos = msg_len[5:0];
        if (req.op == OP_ABSORB) begin
            msg_block[pos] = req.data_byte;
            msg_len = msg_len + 61'd1;
            if (pos == LAST_POS) begin
                sha1_compress();
            end
        end else begin
            msg_block[pos] = PAD_BYTE;
            for (i = pos + 1; i < 64; i++) begin
                msg_block[i] = 8'h00;
            end
            if (pos >= LEN_POS) begin
                sha1_compress();
                for (i = 0; i < 64; i++) begin
                    msg_block[i] = 8'h00;
                end
            end
            bit_len = {msg_len, 3'b000};
            for (i = 0; i < 8; i++) begin
                msg_block[LEN_POS + i] = bit_len[63 - 8*i -: 8];
            end
            sha1_compress();
            for (i = 0; i < 5; i++) begin
                word.digest_word = hash_h[i];
                word.word_index  = i[2:0];
                word.last_word   = (i[2:0] == LAST_IDX);
                digest_q.push_back(word);
            end
            hash_h  = INIT_WORDS;
            msg_len = '0;
        end
    endtask

    task automatic push_req(logic op, logic [7:0] data_byte, bit hold);
        pending_t p;
        p.req.op        = op;
        p.req.data_byte = data_byte;
        p.hold          = hold;
        pending_q.push_back(p);
    endtask

    task automatic add_message(int unsigned len, bit hold);
        int unsigned i;
        for (i = 0; i < len; i++) begin
            push_req(OP_ABSORB, 8'($urandom_range(0, 255)), hold && i == 0);
        end
        push_req(OP_FINISH, 8'($urandom_range(0, 255)), hold && len == 0);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                hash_request(s_data);
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (pending_q.size() != 0 && gap_left == 0 &&
                         !(pending_q[0].hold && digest_q.size() != 0)) begin
                s_valid <= 1'b1;
                s_data  <= pending_q[0].req;
                void'(pending_q.pop_front());
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end
            end
        end
    end

    // Digest sink: the stall pattern is chosen again at random after a random span.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (sink_cycles == 0) begin
                sink_mode   = $urandom_range(0, 3);
                sink_cycles = $urandom_range(20, 80);
            end else begin
                sink_cycles--;
            end
            case (sink_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= (sink_cycles % 4 == 0);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected digest word", m_data.digest_word, 32'h0);
            end else begin
                if (m_data.digest_word != digest_q[0].digest_word) begin
                    report_mismatch("digest_word", m_data.digest_word,
                                    digest_q[0].digest_word);
                end
                if (m_data.word_index != digest_q[0].word_index) begin
                    report_mismatch("word_index", 32'(m_data.word_index),
                                    32'(digest_q[0].word_index));
                end
                if (m_data.last_word != digest_q[0].last_word) begin
                    report_mismatch("last_word", 32'(m_data.last_word),
                                    32'(digest_q[0].last_word));
                end
                void'(digest_q.pop_front());
            end
        end
    end

    initial begin
        int unsigned len;
        int unsigned boundary [4];

        boundary = '{55, 56, 63, 64};

        // Empty message, "abc", extreme bytes, and back-to-back finishes.
        push_req(OP_FINISH, 8'hFF, 1'b0);
        push_req(OP_ABSORB, 8'h61, 1'b0);
        push_req(OP_ABSORB, 8'h62, 1'b0);
        push_req(OP_ABSORB, 8'h63, 1'b0);
        push_req(OP_FINISH, 8'h00, 1'b0);
        push_req(OP_ABSORB, 8'h00, 1'b0);
        push_req(OP_ABSORB, 8'hFF, 1'b0);
        push_req(OP_ABSORB, 8'h55, 1'b0);
        push_req(OP_ABSORB, 8'hAA, 1'b0);
        push_req(OP_FINISH, 8'h00, 1'b0);
        push_req(OP_FINISH, 8'hAA, 1'b0);
        push_req(OP_FINISH, 8'h55, 1'b0);

        foreach (boundary[i]) begin
            add_message(boundary[i], i == 0);
        end
        while (pending_q.size() < 450) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(0, 12);
                5, 6, 7: len = $urandom_range(13, 70);
                default: len = $urandom_range(100, 130);
            endcase
            add_message(len, $urandom_range(0, 3) == 0);
        end

        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_valid) @(posedge aclk);
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (err_count == 0) begin
            $display("sha1_stream_hasher test passed");
        end else begin
            $display("sha1_stream_hasher test failed");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("sha1_stream_hasher test failed");
        $finish;
    end

endmodule
